@@ hdl/zih_pkg.sv @@
`default_nettype none
package zih_pkg;

	localparam int KEY_COUNT       = 781;
	localparam int PIECE_KINDS     = 12;
	localparam int SQUARES         = 64;
	localparam int TURN_KEY        = SQUARES * 12;
	localparam int CASTLE_KEY_BASE = SQUARES * 12 + 1;
	localparam int EP_KEY_BASE     = SQUARES * 12 + 5;
	localparam int OUT_DEPTH       = 3;

	localparam int CMD_W     = 3;
	localparam int PIECE_W   = 4;
	localparam int SQ_W      = 6;
	localparam int KEY_IDX_W = 10;
	localparam int KEY_W     = 64;
	localparam int IN_DATA_W = 88;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_KEY     = 3'd0,
		CMD_ADD_PIECE    = 3'd1,
		CMD_REMOVE_PIECE = 3'd2,
		CMD_SET_EP       = 3'd3,
		CMD_SET_CASTLE   = 3'd4,
		CMD_SET_TURN     = 3'd5
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic fault;
		logic use_a;
		logic use_b;
	} issue_t;

	typedef struct packed {
		logic             fault;
		logic [KEY_W-1:0] hash;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/zobrist_incremental_hasher.sv @@
`default_nettype none
// Zobrist position hasher. Takes one command per cycle while s_axis_tready is high; its key
// reads are issued to the key memory (one write port, two read ports, registered reads) in the
// cycle the item is accepted, and the hash is folded in the cycle after. A three-entry result
// queue absorbs output stalls; tready drops only when that queue and the item in flight would
// fill it. Keys must be loaded before they are used.
module zobrist_incremental_hasher #(
	parameter int KEY_COUNT   = zih_pkg::KEY_COUNT,
	parameter int PIECE_KINDS = zih_pkg::PIECE_KINDS
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// piece[3:0], square[9:4], ep_present[10], side[11], castle_long[12],
	// right_value[13], key_index[23:14], key_value[87:24]
	input  wire logic [zih_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// command[2:0]
	input  wire logic [zih_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// hash[63:0]
	output logic      [zih_pkg::KEY_W-1:0]        m_axis_tdata,
	// fault[0]
	output logic                                  m_axis_tuser
);

	localparam int AW    = $clog2(KEY_COUNT);
	localparam int CNT_W = $clog2(zih_pkg::OUT_DEPTH + 1);

	logic                       accept;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [AW-1:0]              rd_addr_a;
	logic [AW-1:0]              rd_addr_b;
	logic [zih_pkg::KEY_W-1:0]  rd_data_a;
	logic [zih_pkg::KEY_W-1:0]  rd_data_b;
	zih_pkg::issue_t            issue_s1;
	logic [zih_pkg::KEY_W-1:0]  hash_q;
	logic [zih_pkg::KEY_W-1:0]  hash_next;
	logic [CNT_W-1:0]           q_count;
	zih_pkg::result_t           q_head;
	zih_pkg::result_t           push_res;

	assign s_axis_tready = (32'(q_count) + 32'(issue_s1.valid)) < zih_pkg::OUT_DEPTH;
	assign accept        = s_axis_tvalid && s_axis_tready;

	zih_ctrl #(
		.KEY_COUNT   (KEY_COUNT),
		.PIECE_KINDS (PIECE_KINDS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (zih_pkg::cmd_t'(s_axis_tuser)),
		.piece       (s_axis_tdata[3:0]),
		.square      (s_axis_tdata[9:4]),
		.ep_present  (s_axis_tdata[10]),
		.side        (s_axis_tdata[11]),
		.castle_long (s_axis_tdata[12]),
		.right_value (s_axis_tdata[13]),
		.key_index   (s_axis_tdata[23:14]),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.rd_addr_a   (rd_addr_a),
		.rd_addr_b   (rd_addr_b),
		.issue_s1    (issue_s1)
	);

	zih_key_ram #(
		.DEPTH (KEY_COUNT)
	) u_key_ram (
		.clk       (clk),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (s_axis_tdata[87:24]),
		.rd_en     (accept),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	assign hash_next = hash_q
		^ (issue_s1.use_a ? rd_data_a : '0)
		^ (issue_s1.use_b ? rd_data_b : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
		end else if (issue_s1.valid) begin
			hash_q <= hash_next;
		end
	end

	assign push_res.fault = issue_s1.fault;
	assign push_res.hash  = hash_next;

	zih_out_queue #(
		.DEPTH (zih_pkg::OUT_DEPTH)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (issue_s1.valid),
		.push_data (push_res),
		.pop       (m_axis_tready),
		.count     (q_count),
		.head      (q_head)
	);

	assign m_axis_tvalid = q_count != '0;
	assign m_axis_tdata  = q_head.hash;
	assign m_axis_tuser  = q_head.fault;

	assert property (@(posedge clk) disable iff (!arst_n)
		(!issue_s1.valid || issue_s1.fault) |=> hash_q == $past(hash_q))
		else $error("hash changed without a valid, non-faulting item");

	assert property (@(posedge clk) disable iff (!arst_n)
		issue_s1.fault |-> !issue_s1.use_a && !issue_s1.use_b)
		else $error("faulting item reads keys");

	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(q_count) + 32'(issue_s1.valid)) <= zih_pkg::OUT_DEPTH)
		else $error("result queue overcommitted");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=>
		(m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result item changed");

endmodule
`default_nettype wire

@@ hdl/zih_key_ram.sv @@
`default_nettype none
module zih_key_ram #(
	parameter int DEPTH = zih_pkg::KEY_COUNT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [AW-1:0]              wr_addr,
	input  wire logic [zih_pkg::KEY_W-1:0]  wr_data,
	input  wire logic                       rd_en,
	input  wire logic [AW-1:0]              rd_addr_a,
	input  wire logic [AW-1:0]              rd_addr_b,
	output logic      [zih_pkg::KEY_W-1:0]  rd_data_a,
	output logic      [zih_pkg::KEY_W-1:0]  rd_data_b
);

	logic [zih_pkg::KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule
`default_nettype wire

@@ hdl/zih_ctrl.sv @@
`default_nettype none
module zih_ctrl #(
	parameter int KEY_COUNT   = zih_pkg::KEY_COUNT,
	parameter int PIECE_KINDS = zih_pkg::PIECE_KINDS,
	parameter int AW          = $clog2(KEY_COUNT),
	parameter int PW          = $clog2(PIECE_KINDS)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire zih_pkg::cmd_t                   cmd,
	input  wire logic [zih_pkg::PIECE_W-1:0]     piece,
	input  wire logic [zih_pkg::SQ_W-1:0]        square,
	input  wire logic                            ep_present,
	input  wire logic                            side,
	input  wire logic                            castle_long,
	input  wire logic                            right_value,
	input  wire logic [zih_pkg::KEY_IDX_W-1:0]   key_index,
	output logic                                 wr_en,
	output logic      [AW-1:0]                   wr_addr,
	output logic      [AW-1:0]                   rd_addr_a,
	output logic      [AW-1:0]                   rd_addr_b,
	output zih_pkg::issue_t                      issue_s1
);

	logic [zih_pkg::SQUARES-1:0] occ_q [PIECE_KINDS];
	logic                        ep_valid_q;
	logic [zih_pkg::SQ_W-1:0]    ep_sq_q;
	logic [3:0]                  castle_q;
	logic                        side_q;

	logic                        piece_ok;
	logic [PW-1:0]               pidx;
	logic [zih_pkg::SQUARES-1:0] cur_occ;
	logic                        present;
	logic [1:0]                  pos;
	logic                        ep_same;
	logic                        fault;
	logic                        use_a;
	logic                        use_b;

	assign piece_ok = 32'(piece) < PIECE_KINDS;
	assign pidx     = PW'(piece);
	assign cur_occ  = piece_ok ? occ_q[pidx] : '0;
	assign present  = cur_occ[square];
	assign pos      = {side, ~castle_long};
	assign ep_same  = (ep_present == ep_valid_q) && (!ep_present || (square == ep_sq_q));

	assign wr_en   = accept && (cmd == zih_pkg::CMD_LOAD_KEY) && (32'(key_index) < KEY_COUNT);
	assign wr_addr = AW'(key_index);

	always_comb begin
		fault     = 1'b0;
		use_a     = 1'b0;
		use_b     = 1'b0;
		rd_addr_a = AW'({piece, square});
		rd_addr_b = AW'(zih_pkg::EP_KEY_BASE) + AW'(square[2:0]);
		case (cmd)
			zih_pkg::CMD_ADD_PIECE, zih_pkg::CMD_REMOVE_PIECE: begin
				if (!piece_ok || ((cmd == zih_pkg::CMD_ADD_PIECE) == present)) begin
					fault = 1'b1;
				end else begin
					use_a = 1'b1;
				end
			end
			zih_pkg::CMD_SET_EP: begin
				rd_addr_a = AW'(zih_pkg::EP_KEY_BASE) + AW'(ep_sq_q[2:0]);
				if (!ep_same) begin
					use_a = ep_valid_q;
					use_b = ep_present;
				end
			end
			zih_pkg::CMD_SET_CASTLE: begin
				rd_addr_a = AW'(zih_pkg::CASTLE_KEY_BASE) + AW'(pos);
				use_a     = castle_q[pos] != right_value;
			end
			zih_pkg::CMD_SET_TURN: begin
				rd_addr_a = AW'(zih_pkg::TURN_KEY);
				use_a     = side != side_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIECE_KINDS; i++) begin
				occ_q[i] <= '0;
			end
			ep_valid_q <= 1'b0;
			ep_sq_q    <= '0;
			castle_q   <= '0;
			side_q     <= 1'b0;
			issue_s1   <= '0;
		end else begin
			issue_s1 <= '{valid: accept, fault: accept && fault,
				use_a: accept && use_a, use_b: accept && use_b};
			if (accept) begin
				case (cmd)
					zih_pkg::CMD_ADD_PIECE, zih_pkg::CMD_REMOVE_PIECE: begin
						if (use_a) begin
							occ_q[pidx][square] <= (cmd == zih_pkg::CMD_ADD_PIECE);
						end
					end
					zih_pkg::CMD_SET_EP: begin
						if (!ep_same) begin
							ep_valid_q <= ep_present;
							ep_sq_q    <= ep_present ? square : '0;
						end
					end
					zih_pkg::CMD_SET_CASTLE: begin
						if (use_a) begin
							castle_q[pos] <= right_value;
						end
					end
					zih_pkg::CMD_SET_TURN: begin
						side_q <= side;
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

@@ hdl/zih_out_queue.sv @@
`default_nettype none
module zih_out_queue #(
	parameter int DEPTH = zih_pkg::OUT_DEPTH,
	parameter int PTR_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire zih_pkg::result_t  push_data,
	input  wire logic              pop,
	output logic [CNT_W-1:0]       count,
	output zih_pkg::result_t       head
);

	zih_pkg::result_t  buf_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_pop;

	assign count  = count_q;
	assign head   = buf_q[rd_ptr_q];
	assign do_pop = pop && (count_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

endmodule
`default_nettype wire
